// ----- src/pgr_pkg.sv -----
package pgr_pkg;

    // Sizing
    localparam int MAX_WIDTH = 4096;
    localparam int PAL_DEPTH = 256;
    localparam int PAL_AW    = $clog2(PAL_DEPTH);
    localparam int CNT_W     = 13;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int QDEPTH    = 4;
    localparam int Q_AW      = $clog2(QDEPTH);
    localparam int Q_CW      = $clog2(QDEPTH + 1);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_FORMAT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 2'd2;

    // Output depth codes
    localparam logic [1:0] DEST_1BIT     = 2'd0;
    localparam logic [1:0] DEST_2BIT_INV = 2'd1;
    localparam logic [1:0] DEST_4BIT     = 2'd2;

    // Source format codes
    localparam logic [2:0] SRC_GRAY2  = 3'd0;
    localparam logic [2:0] SRC_GRAY4  = 3'd1;
    localparam logic [2:0] SRC_GRAY8  = 3'd2;
    localparam logic [2:0] SRC_IDX2   = 3'd3;
    localparam logic [2:0] SRC_IDX4   = 3'd4;
    localparam logic [2:0] SRC_IDX8   = 3'd5;
    localparam logic [2:0] SRC_RGB24  = 3'd6;
    localparam logic [2:0] SRC_RGBA32 = 3'd7;

    // Reset values
    localparam logic [1:0]       DEST_RESET     = DEST_2BIT_INV;
    localparam logic [2:0]       SRC_RESET      = SRC_GRAY8;
    localparam logic [CNT_W-1:0] WIDTH_M1_RESET = CNT_W'(800 - 1);
    localparam logic [3:0]       FREE_RESET     = 4'd8;

    localparam logic [7:0] GRAY2_LUT [4] = '{8'h00, 8'h55, 8'haa, 8'hff};

    typedef enum logic [1:0] {
        QOP_PAL,
        QOP_GRAY,
        QOP_INDEX
    } t_qop;

    typedef struct packed {
        t_qop       op;
        logic [7:0] addr;
        logic [7:0] gray;
        logic       last;
    } t_qent;

    typedef struct packed {
        logic [1:0]       dest_mode;
        logic [2:0]       src_format;
        logic [CNT_W-1:0] width_m1;
        logic             restart;
    } t_cfg;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       line_end;
    } t_oent;

    // (r + 2g + b) / 4
    function automatic logic [7:0] rgb_gray(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b);
        logic [9:0] sum;
        sum = {2'b00, r} + {1'b0, g, 1'b0} + {2'b00, b};
        return sum[9:2];
    endfunction

endpackage

// ----- src/pgr_if.sv -----
interface pgr_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] data_byte;
    logic [7:0] pal_index;
    logic [7:0] pal_red;
    logic [7:0] pal_green;
    logic [7:0] pal_blue;

    modport source (output valid, req_type, data_byte, pal_index, pal_red, pal_green,
                    pal_blue, input ready);
    modport sink   (input valid, req_type, data_byte, pal_index, pal_red, pal_green,
                    pal_blue, output ready);
endinterface

interface pgr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       line_end;

    modport source (output valid, out_byte, line_end, input ready);
    modport sink   (input valid, out_byte, line_end, output ready);
endinterface

// ----- src/pixel_gray_reduce_pack.sv -----
// A source byte or colour pixel is registered in the queue, the pixel stage and the result buffer.
// Throughput, while the queue has room: one item per cycle for 8-bit gray, 8-bit index, colour
//   bytes and palette writes; 2- and 4-bit sources take a new byte once the unpacker has queued
//   its pixels (fewer at line end), one a cycle. Results leave one byte per cycle when ready.
// Reset (synchronous, active low) restores the registers to their defaults and clears the
//   line position; palette entries are undefined until written.
module pixel_gray_reduce_pack (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    pgr_in_if.sink                          i_pix,
    pgr_out_if.source                       o_pix,
    input  logic                            i_cfg_we,
    input  logic [pgr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pgr_pkg::CFG_W-1:0]       i_cfg_data
);

    logic [1:0]                 r_dest_mode;
    logic [2:0]                 r_src_format;
    logic [pgr_pkg::CNT_W-1:0]  r_width_m1, n_width_m1;
    logic                       restart;
    pgr_pkg::t_cfg              cfg;

    logic                       q_push;
    pgr_pkg::t_qent             q_in;
    logic                       q_full;
    logic                       q_valid;
    pgr_pkg::t_qent             q_out;
    logic                       q_pop;

    assign restart = i_cfg_we && ((i_cfg_idx == pgr_pkg::CFG_DEST_MODE) ||
                                  (i_cfg_idx == pgr_pkg::CFG_SRC_FORMAT) ||
                                  (i_cfg_idx == pgr_pkg::CFG_LINE_WIDTH));

    // clamp line width to one at the bottom and the maximum at the top
    always_comb begin
        if (i_cfg_data == '0) begin
            n_width_m1 = '0;
        end else if (32'(i_cfg_data) > pgr_pkg::MAX_WIDTH) begin
            n_width_m1 = pgr_pkg::CNT_W'(pgr_pkg::MAX_WIDTH - 1);
        end else begin
            n_width_m1 = pgr_pkg::CNT_W'(i_cfg_data - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_mode  <= pgr_pkg::DEST_RESET;
            r_src_format <= pgr_pkg::SRC_RESET;
            r_width_m1   <= pgr_pkg::WIDTH_M1_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pgr_pkg::CFG_DEST_MODE:  r_dest_mode  <= i_cfg_data[1:0];
                pgr_pkg::CFG_SRC_FORMAT: r_src_format <= i_cfg_data[2:0];
                pgr_pkg::CFG_LINE_WIDTH: r_width_m1   <= n_width_m1;
                default:                 r_dest_mode  <= r_dest_mode;
            endcase
        end
    end

    assign cfg.dest_mode  = r_dest_mode;
    assign cfg.src_format = r_src_format;
    assign cfg.width_m1   = r_width_m1;
    assign cfg.restart    = restart;

    pgr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_pix    (i_pix),
        .o_q_push (q_push),
        .o_q_ent  (q_in),
        .i_q_full (q_full)
    );

    pgr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_ent   (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_ent   (q_out),
        .i_pop   (q_pop)
    );

    pgr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_valid (q_valid),
        .i_q_ent   (q_out),
        .o_q_pop   (q_pop),
        .o_pix     (o_pix)
    );

endmodule

// ----- src/pgr_front.sv -----
module pgr_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pgr_pkg::t_cfg     i_cfg,
    pgr_in_if.sink            i_pix,
    output logic              o_q_push,
    output pgr_pkg::t_qent    o_q_ent,
    input  logic              i_q_full
);

    logic [pgr_pkg::CNT_W-1:0] r_count, n_count;
    logic [1:0]                r_phase, n_phase;
    logic [1:0]                r_left, n_left;
    logic [7:0]                r_hold, n_hold;
    logic [7:0]                r_red, n_red;
    logic [7:0]                r_green, n_green;

    logic                      last;
    logic                      two_bit;
    logic [7:0]                src_byte;
    pgr_pkg::t_qent            pix;

    function automatic pgr_pkg::t_qent unpack(input logic [2:0] fmt, input logic [7:0] b);
        pgr_pkg::t_qent e;
        e      = '0;
        e.op   = pgr_pkg::QOP_GRAY;
        e.gray = b;
        case (fmt)
            pgr_pkg::SRC_GRAY2: e.gray = pgr_pkg::GRAY2_LUT[b[7:6]];
            pgr_pkg::SRC_GRAY4: e.gray = {b[7:4], b[7:4]};
            pgr_pkg::SRC_IDX2: begin
                e.op   = pgr_pkg::QOP_INDEX;
                e.addr = {6'b0, b[7:6]};
            end
            pgr_pkg::SRC_IDX4: begin
                e.op   = pgr_pkg::QOP_INDEX;
                e.addr = {4'b0, b[7:4]};
            end
            pgr_pkg::SRC_IDX8: begin
                e.op   = pgr_pkg::QOP_INDEX;
                e.addr = b;
            end
            default: e.gray = b;
        endcase
        return e;
    endfunction

    assign i_pix.ready = (r_left == 2'd0) && !i_q_full;
    assign src_byte    = (r_left != 2'd0) ? r_hold : i_pix.data_byte;
    assign two_bit     = (i_cfg.src_format == pgr_pkg::SRC_GRAY2) ||
                         (i_cfg.src_format == pgr_pkg::SRC_IDX2);
    assign last        = (r_count == i_cfg.width_m1);

    always_comb begin
        pix      = unpack(i_cfg.src_format, src_byte);
        pix.last = last;
        n_count  = r_count;
        n_phase  = r_phase;
        n_left   = r_left;
        n_hold   = r_hold;
        n_red    = r_red;
        n_green  = r_green;
        o_q_push = 1'b0;
        o_q_ent  = pix;
        if (i_cfg.restart) begin
            n_count = '0;
            n_phase = 2'd0;
            n_left  = 2'd0;
        end else if (r_left != 2'd0) begin
            // drain the rest of a sub-byte source byte, one pixel a cycle while the queue has room
            if (!i_q_full) begin
                o_q_push = 1'b1;
                if (last) begin
                    n_count = '0;
                    n_left  = 2'd0;
                end else begin
                    n_count = r_count + 1'b1;
                    n_left  = r_left - 2'd1;
                    n_hold  = two_bit ? {r_hold[5:0], 2'b00} : {r_hold[3:0], 4'b0000};
                end
            end
        end else if (i_pix.valid && i_pix.ready) begin
            if (i_pix.req_type) begin
                o_q_push     = 1'b1;
                o_q_ent      = '0;
                o_q_ent.op   = pgr_pkg::QOP_PAL;
                o_q_ent.addr = i_pix.pal_index;
                o_q_ent.gray = pgr_pkg::rgb_gray(i_pix.pal_red, i_pix.pal_green,
                                                 i_pix.pal_blue);
            end else begin
                case (i_cfg.src_format) inside
                    pgr_pkg::SRC_RGB24, pgr_pkg::SRC_RGBA32: begin
                        case (r_phase)
                            2'd0: begin
                                n_red   = i_pix.data_byte;
                                n_phase = 2'd1;
                            end
                            2'd1: begin
                                n_green = i_pix.data_byte;
                                n_phase = 2'd2;
                            end
                            2'd2: begin
                                o_q_push     = 1'b1;
                                o_q_ent      = '0;
                                o_q_ent.op   = pgr_pkg::QOP_GRAY;
                                o_q_ent.gray = pgr_pkg::rgb_gray(r_red, r_green,
                                                                 i_pix.data_byte);
                                o_q_ent.last = last;
                                // a line end skips the alpha phase, so the next byte counts as red
                                n_phase = (i_cfg.src_format == pgr_pkg::SRC_RGBA32 && !last)
                                          ? 2'd3 : 2'd0;
                                n_count = last ? '0 : r_count + 1'b1;
                            end
                            default: n_phase = 2'd0;
                        endcase
                    end
                    pgr_pkg::SRC_GRAY2, pgr_pkg::SRC_IDX2: begin
                        o_q_push = 1'b1;
                        n_count  = last ? '0 : r_count + 1'b1;
                        n_left   = last ? 2'd0 : 2'd3;
                        n_hold   = {i_pix.data_byte[5:0], 2'b00};
                    end
                    pgr_pkg::SRC_GRAY4, pgr_pkg::SRC_IDX4: begin
                        o_q_push = 1'b1;
                        n_count  = last ? '0 : r_count + 1'b1;
                        n_left   = last ? 2'd0 : 2'd1;
                        n_hold   = {i_pix.data_byte[3:0], 4'b0000};
                    end
                    default: begin
                        o_q_push = 1'b1;
                        n_count  = last ? '0 : r_count + 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_phase <= 2'd0;
            r_left  <= 2'd0;
        end else begin
            r_count <= n_count;
            r_phase <= n_phase;
            r_left  <= n_left;
        end
        r_hold  <= n_hold;
        r_red   <= n_red;
        r_green <= n_green;
    end

endmodule

// ----- src/pgr_queue.sv -----
module pgr_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pgr_pkg::t_qent  i_ent,
    output logic            o_full,
    output logic            o_valid,
    output pgr_pkg::t_qent  o_ent,
    input  logic            i_pop
);

    pgr_pkg::t_qent                 r_mem [pgr_pkg::QDEPTH];
    logic [pgr_pkg::Q_AW-1:0]       r_head, r_tail;
    logic [pgr_pkg::Q_CW-1:0]       r_cnt, n_cnt;

    assign o_full  = (r_cnt == pgr_pkg::Q_CW'(pgr_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_ent   = r_mem[r_head];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_cnt  <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_tail <= r_tail + 1'b1;
            end
            if (i_pop) begin
                r_head <= r_head + 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_tail] <= i_ent;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue pop while empty");

endmodule

// ----- src/pgr_back.sv -----
module pgr_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pgr_pkg::t_cfg   i_cfg,
    input  logic            i_q_valid,
    input  pgr_pkg::t_qent  i_q_ent,
    output logic            o_q_pop,
    pgr_out_if.source       o_pix
);

    // palette store, gray value per entry
    logic [7:0]                 r_mem [pgr_pkg::PAL_DEPTH];
    logic [7:0]                 r_rd_data;
    logic                       q_in_range;

    // pixel stage
    logic                       r_s2_valid;
    logic                       r_s2_lookup;
    logic                       r_s2_oor;
    logic [7:0]                 r_s2_gray;
    logic                       r_s2_last;

    // packer
    logic [7:0]                 r_pack, n_pack;
    logic [3:0]                 r_free, n_free;

    // result buffer
    pgr_pkg::t_oent             r_obuf [2];
    logic                       r_ohead;
    logic [1:0]                 r_ocnt;

    logic [7:0]                 gray;
    logic [3:0]                 bits;
    logic [3:0]                 val;
    logic [7:0]                 pk_new;
    logic [3:0]                 free_new;
    logic                       emit;
    pgr_pkg::t_oent             emit_ent;
    logic                       s2_fire;
    logic                       o_push;
    logic                       o_pop;

    assign q_in_range = ({1'b0, i_q_ent.addr} < 9'(pgr_pkg::PAL_DEPTH));

    assign gray = r_s2_lookup ? (r_s2_oor ? 8'h00 : r_rd_data) : r_s2_gray;

    always_comb begin
        case (i_cfg.dest_mode)
            pgr_pkg::DEST_1BIT: begin
                bits = 4'd1;
                val  = {3'b000, gray[7]};
            end
            pgr_pkg::DEST_2BIT_INV: begin
                bits = 4'd2;
                val  = {2'b00, ~gray[7:6]};
            end
            default: begin
                bits = 4'd4;
                val  = gray[7:4];
            end
        endcase
        pk_new            = (r_pack << bits) | {4'h0, val};
        free_new          = r_free - bits;
        emit              = r_s2_last || (free_new == 4'd0);
        emit_ent.line_end = r_s2_last;
        // flush a partial byte into the top bits at line end
        emit_ent.out_byte = r_s2_last ? (pk_new << free_new[2:0]) : pk_new;
    end

    assign s2_fire = r_s2_valid && (!emit || (r_ocnt != 2'd2));
    assign o_push  = s2_fire && emit;
    assign o_pop   = o_pix.valid && o_pix.ready;
    assign o_q_pop = i_q_valid && (!r_s2_valid || s2_fire);

    always_comb begin
        n_pack = r_pack;
        n_free = r_free;
        if (i_cfg.restart) begin
            n_pack = '0;
            n_free = pgr_pkg::FREE_RESET;
        end else if (s2_fire) begin
            n_pack = emit ? 8'h00 : pk_new;
            n_free = emit ? pgr_pkg::FREE_RESET : free_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            if (i_q_ent.op == pgr_pkg::QOP_PAL && q_in_range) begin
                r_mem[i_q_ent.addr[pgr_pkg::PAL_AW-1:0]] <= i_q_ent.gray;
            end
            r_rd_data <= r_mem[i_q_ent.addr[pgr_pkg::PAL_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_pack     <= '0;
            r_free     <= pgr_pkg::FREE_RESET;
            r_ohead    <= 1'b0;
            r_ocnt     <= 2'd0;
        end else begin
            r_pack <= n_pack;
            r_free <= n_free;
            if (o_q_pop) begin
                r_s2_valid <= (i_q_ent.op != pgr_pkg::QOP_PAL);
            end else if (s2_fire) begin
                r_s2_valid <= 1'b0;
            end
            if (o_pop) begin
                r_ohead <= ~r_ohead;
            end
            case ({o_push, o_pop})
                2'b10:   r_ocnt <= r_ocnt + 2'd1;
                2'b01:   r_ocnt <= r_ocnt - 2'd1;
                default: r_ocnt <= r_ocnt;
            endcase
        end
        if (o_q_pop) begin
            r_s2_lookup <= (i_q_ent.op == pgr_pkg::QOP_INDEX);
            r_s2_oor    <= !q_in_range;
            r_s2_gray   <= i_q_ent.gray;
            r_s2_last   <= i_q_ent.last;
        end
        if (o_push) begin
            r_obuf[r_ohead ^ r_ocnt[0]] <= emit_ent;
        end
    end

    assign o_pix.valid    = (r_ocnt != 2'd0);
    assign o_pix.out_byte = r_obuf[r_ohead].out_byte;
    assign o_pix.line_end = r_obuf[r_ohead].line_end;

    a_obuf_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt != 2'd3)
        else $error("result buffer overfilled");

    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free != 4'd0) && (r_free <= pgr_pkg::FREE_RESET))
        else $error("packer free bit count out of range");

    a_line_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_fire && r_s2_last |=> (r_free == pgr_pkg::FREE_RESET) && (r_pack == 8'h00))
        else $error("packer not cleared after line end");

endmodule
